// ===== hw/rtl/dsm_serial_frame_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame decoder
// Concurrent checks that use clk_i and rst_ni of the including module.
// ----------------------------------------------------------------------------
`ifndef DSM_SERIAL_FRAME_DECODER_TOP_ASSERT_SVH
`define DSM_SERIAL_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DSM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`define DSM_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define DSM_ASSERT_NEVER(label, cond, msg)
`define DSM_ASSERT_IMPLY(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/dsm_sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame decoder package
// Shared constants, register codes and transaction types of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsm_sfd_pkg;

  localparam int unsigned FRAME_BYTES_DEF  = 16;
  localparam int unsigned MAX_CHANNELS_DEF = 12;
  localparam int unsigned CONTROL_BYTES    = 4;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [10:0] PULSE_BASE = 11'd988;
  localparam logic [10:0] PULSE_MAX  = 11'd2011;

  localparam logic        HIRES_RESET      = 1'b1;
  localparam logic [3:0]  CH_COUNT_RESET   = 4'd12;
  localparam logic [3:0]  SKIP_CH_RESET    = 4'd0;
  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd5000;
  localparam logic [31:0] VTX_MASK_RESET   = 32'hE000_F000;
  localparam logic [31:0] VTX_PATTERN_RESET = 32'hE000_E000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIRES_MODE    = 3'd0,
    CFG_CHANNEL_COUNT = 3'd1,
    CFG_SKIP_CHANNEL  = 3'd2,
    CFG_GAP_TIMEOUT   = 3'd3,
    CFG_VTX_MASK      = 3'd4,
    CFG_VTX_PATTERN   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HI,
    BK_LO,
    BK_WORD,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic        hires_mode;
    logic [3:0]  channel_count;
    logic [3:0]  skip_channel;
    logic [15:0] gap_timeout_us;
    logic [31:0] vtx_mask;
    logic [31:0] vtx_pattern;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  rx_byte;
    logic [15:0] gap_us;
    logic [3:0]  read_channel;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] pulse_us;
    logic        control_frame;
    logic [31:0] control_word;
    logic        phase_bit;
  } out_item_t;

  // One queued operation: either a channel read or a completed frame.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  read_channel;
    logic        control_frame;
    logic [31:0] control_word;
    logic        phase_bit;
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dsm_sfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsm_sfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dsm_sfd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsm_sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

`default_nettype wire

// ===== hw/rtl/dsm_sfd_queue.sv =====
// ----------------------------------------------------------------------------
// Operation queue
// Short FIFO between the byte front end and the decode back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsm_sfd_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dsm_sfd_pkg::op_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output dsm_sfd_pkg::op_t      head_o,
  output logic                  empty_o
);
  localparam int unsigned DEPTH = dsm_sfd_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  dsm_sfd_pkg::op_t  slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

`default_nettype wire

// ===== hw/rtl/dsm_sfd_front.sv =====
// ----------------------------------------------------------------------------
// Byte front end
// Accepts transactions, assembles frame bytes and queues reads and frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsm_sfd_front #(
  parameter int unsigned FRAME_BYTES = dsm_sfd_pkg::FRAME_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dsm_sfd_pkg::cfg_t                cfg_i,
  dsm_sfd_stream_if.sink                        in_i,
  input  wire logic                             q_full_i,
  output logic                                  q_push_o,
  output dsm_sfd_pkg::op_t                      q_data_o,
  input  wire logic                             frame_done_i,
  output logic                                  ram_we_o,
  output logic [$clog2(FRAME_BYTES)-1:0]        ram_waddr_o,
  output logic [7:0]                            ram_wdata_o
);
  localparam int unsigned FB_IDX_W = $clog2(FRAME_BYTES);
  localparam int unsigned FB_POS_W = $clog2(FRAME_BYTES + 1);
  localparam logic [FB_POS_W-1:0] POS_FULL  = FB_POS_W'(FRAME_BYTES);
  localparam logic [FB_POS_W-1:0] POS_PHASE = FB_POS_W'(2);

  logic [FB_POS_W-1:0] pos_q, pos_d;
  logic                busy_q, busy_d;
  logic                phase_q, phase_d;
  logic [31:0]         word_q, word_d;

  dsm_sfd_pkg::in_item_t item;
  logic                  is_read;
  logic                  accept;
  logic [FB_POS_W-1:0]   pos_eff;
  logic [FB_POS_W-1:0]   pos_next;
  logic                  room;
  logic [31:0]           word_new;

  assign item    = in_i.payload;
  assign is_read = (item.command == dsm_sfd_pkg::CMD_READ);
  // Reads keep flowing while a frame decodes; bytes wait so the buffer holds still.
  assign in_i.ready = !q_full_i && (is_read || !busy_q);
  assign accept     = in_i.valid && in_i.ready;

  assign pos_eff  = (item.gap_us > cfg_i.gap_timeout_us) ? '0 : pos_q;
  assign room     = (pos_eff < POS_FULL);
  assign pos_next = pos_eff + FB_POS_W'(1);
  assign word_new = {word_q[23:0], item.rx_byte};

  assign ram_waddr_o = pos_eff[FB_IDX_W-1:0];
  assign ram_wdata_o = item.rx_byte;

  always_comb begin
    pos_d    = pos_q;
    busy_d   = busy_q;
    phase_d  = phase_q;
    word_d   = word_q;
    ram_we_o = 1'b0;
    q_push_o = 1'b0;

    q_data_o              = '0;
    q_data_o.read_channel = item.read_channel;
    q_data_o.control_word = word_new;
    q_data_o.phase_bit    = phase_q;
    q_data_o.control_frame =
      ((word_new & cfg_i.vtx_mask) == cfg_i.vtx_pattern) && !phase_q;

    if (is_read) begin
      q_data_o.kind = dsm_sfd_pkg::KIND_READ;
    end else begin
      q_data_o.kind = dsm_sfd_pkg::KIND_FRAME;
    end

    if (frame_done_i) begin
      busy_d = 1'b0;
    end

    if (accept) begin
      if (is_read) begin
        q_push_o = 1'b1;
      end else begin
        pos_d = pos_eff;
        if (room) begin
          ram_we_o = 1'b1;
          pos_d    = pos_next;
          word_d   = word_new;
          if (pos_eff == POS_PHASE) begin
            phase_d = item.rx_byte[7];
          end
          if (pos_next == POS_FULL) begin
            q_push_o = 1'b1;
            busy_d   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    word_q  <= word_d;
  end
endmodule

`default_nettype wire

// ===== hw/rtl/dsm_sfd_back.sv =====
// ----------------------------------------------------------------------------
// Decode back end
// Decodes frames into the channel table, answers reads, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsm_sfd_back #(
  parameter int unsigned FRAME_BYTES  = dsm_sfd_pkg::FRAME_BYTES_DEF,
  parameter int unsigned MAX_CHANNELS = dsm_sfd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dsm_sfd_pkg::cfg_t          cfg_i,
  input  wire logic                       q_empty_i,
  input  wire dsm_sfd_pkg::op_t           q_head_i,
  output logic                            q_pop_o,
  output logic [$clog2(FRAME_BYTES)-1:0]  ram_raddr_o,
  input  wire logic [7:0]                 ram_rdata_i,
  output logic                            frame_done_o,
  dsm_sfd_stream_if.source                out_o
);
  localparam int unsigned FB_IDX_W = $clog2(FRAME_BYTES);
  localparam int unsigned FB_POS_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned WIDX_W   = FB_POS_W - 1;
  localparam int unsigned CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [FB_POS_W-1:0] LEN_FULL = FB_POS_W'(FRAME_BYTES);
  localparam logic [FB_POS_W-1:0] LEN_CTRL =
    FB_POS_W'(FRAME_BYTES - dsm_sfd_pkg::CONTROL_BYTES);
  localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

  dsm_sfd_pkg::back_state_e state_q, state_d;
  dsm_sfd_pkg::op_t         cur_q, cur_d;
  logic [WIDX_W-1:0]        widx_q, widx_d;
  logic [7:0]               hi_q, hi_d;
  logic [10:0]              chan_q [MAX_CHANNELS];
  logic                     out_valid_q, out_valid_d;
  dsm_sfd_pkg::out_item_t   out_q, out_d;

  logic                out_free;
  logic [FB_POS_W-1:0] lo_pos;
  logic [FB_POS_W-1:0] hi_pos;
  logic [FB_POS_W-1:0] data_len;
  logic                more_words;
  logic [3:0]          dec_ch;
  logic [10:0]         dec_val;
  logic                dec_keep;
  logic                chan_we;
  logic [3:0]          rd_ch;
  logic                rd_in_range;
  logic [10:0]         rd_val;
  logic [11:0]         rd_sum;
  logic [10:0]         rd_pulse;

  assign out_free = !out_valid_q || out_o.ready;

  // Channel word w sits at bytes 2w (high) and 2w+1 (low).
  assign lo_pos     = {widx_q, 1'b1};
  assign hi_pos     = lo_pos - FB_POS_W'(1);
  assign data_len   = cur_q.control_frame ? LEN_CTRL : LEN_FULL;
  assign more_words = (lo_pos < data_len);

  assign dec_ch  = cfg_i.hires_mode ? hi_q[6:3] : hi_q[5:2];
  assign dec_val = cfg_i.hires_mode ? {hi_q[2:0], ram_rdata_i}
                                    : {1'b0, hi_q[1:0], ram_rdata_i};
  assign dec_keep = (dec_ch < cfg_i.channel_count) && ({1'b0, dec_ch} < MAX_CH) &&
                    !((cfg_i.skip_channel != 4'd0) && (dec_ch == cfg_i.skip_channel));

  assign rd_ch       = q_head_i.read_channel;
  assign rd_in_range = (rd_ch < cfg_i.channel_count) && ({1'b0, rd_ch} < MAX_CH);

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (rd_ch[CH_IDX_W-1:0] == CH_IDX_W'(i)) begin
        rd_val = chan_q[i];
      end
    end
  end

  // A value stored in 11-bit mode can overflow when read in 10-bit mode.
  assign rd_sum = {1'b0, dsm_sfd_pkg::PULSE_BASE} +
                  (cfg_i.hires_mode ? {2'b00, rd_val[10:1]} : {1'b0, rd_val});
  assign rd_pulse = !rd_in_range ? '0 :
                    (rd_sum > {1'b0, dsm_sfd_pkg::PULSE_MAX}) ? dsm_sfd_pkg::PULSE_MAX
                                                              : rd_sum[10:0];

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    widx_d       = widx_q;
    hi_d         = hi_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    q_pop_o      = 1'b0;
    frame_done_o = 1'b0;
    chan_we      = 1'b0;
    ram_raddr_o  = hi_pos[FB_IDX_W-1:0];

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      dsm_sfd_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.kind == dsm_sfd_pkg::KIND_READ) begin
            if (out_free) begin
              q_pop_o             = 1'b1;
              out_valid_d         = 1'b1;
              out_d               = '0;
              out_d.result_kind   = dsm_sfd_pkg::KIND_READ;
              out_d.pulse_us      = rd_pulse;
            end
          end else begin
            q_pop_o = 1'b1;
            cur_d   = q_head_i;
            widx_d  = WIDX_W'(1);
            state_d = dsm_sfd_pkg::BK_HI;
          end
        end
      end
      dsm_sfd_pkg::BK_HI: begin
        if (more_words) begin
          state_d = dsm_sfd_pkg::BK_LO;
        end else begin
          state_d = dsm_sfd_pkg::BK_DONE;
        end
      end
      dsm_sfd_pkg::BK_LO: begin
        ram_raddr_o = lo_pos[FB_IDX_W-1:0];
        hi_d        = ram_rdata_i;
        state_d     = dsm_sfd_pkg::BK_WORD;
      end
      dsm_sfd_pkg::BK_WORD: begin
        chan_we = dec_keep;
        widx_d  = widx_q + WIDX_W'(1);
        state_d = dsm_sfd_pkg::BK_HI;
      end
      dsm_sfd_pkg::BK_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.result_kind   = dsm_sfd_pkg::KIND_FRAME;
          out_d.pulse_us      = '0;
          out_d.control_frame = cur_q.control_frame;
          out_d.control_word  = cur_q.control_word;
          out_d.phase_bit     = cur_q.phase_bit;
          frame_done_o        = 1'b1;
          state_d             = dsm_sfd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = dsm_sfd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsm_sfd_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        chan_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (chan_we && (dec_ch[CH_IDX_W-1:0] == CH_IDX_W'(i))) begin
          chan_q[i] <= dec_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    widx_q <= widx_d;
    hi_q   <= hi_d;
    out_q  <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
endmodule

`default_nettype wire

// ===== hw/rtl/dsm_serial_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Serial frame decoder, top level
// Builds radio receiver frames from a byte stream and serves channel reads.
//
// in_i carries one command per transaction: a received byte with the gap
// since the previous byte, or a read of one channel. out_o carries one
// result per transaction: a completion report when a frame's last byte
// arrives, or the pulse width answering a read. Bytes that do not complete
// a frame give no result. Registers are written through cfg_we_i,
// cfg_index_i and cfg_data_i, one per cycle; the user must write them only
// while the block is idle, which the block does not enforce. A read answer
// is registered in the queue, then in the result register. A completed
// frame is decoded through the single read port of the frame buffer, each
// channel word in states BK_HI, BK_LO and BK_WORD, then the report is
// registered in BK_DONE. While a frame decodes, new bytes wait; reads are
// still taken into the two-entry queue. Reset clears the channel table,
// the byte position and the result valid flag, and loads the register
// defaults. When the receiver stalls, the result register holds and the
// queue fills, then in_i.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dsm_serial_frame_decoder_top_assert.svh"

module dsm_serial_frame_decoder_top #(
  parameter int unsigned FRAME_BYTES  = dsm_sfd_pkg::FRAME_BYTES_DEF,
  parameter int unsigned MAX_CHANNELS = dsm_sfd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dsm_sfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dsm_sfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dsm_sfd_stream_if.sink                          in_i,
  dsm_sfd_stream_if.source                        out_o
);
  localparam int unsigned FB_IDX_W = $clog2(FRAME_BYTES);

  dsm_sfd_pkg::cfg_t cfg_q;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  dsm_sfd_pkg::op_t  q_wdata;
  dsm_sfd_pkg::op_t  q_head;
  logic              frame_done;
  logic              ram_we;
  logic [FB_IDX_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [FB_IDX_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hires_mode     <= dsm_sfd_pkg::HIRES_RESET;
      cfg_q.channel_count  <= dsm_sfd_pkg::CH_COUNT_RESET;
      cfg_q.skip_channel   <= dsm_sfd_pkg::SKIP_CH_RESET;
      cfg_q.gap_timeout_us <= dsm_sfd_pkg::GAP_TIMEOUT_RESET;
      cfg_q.vtx_mask       <= dsm_sfd_pkg::VTX_MASK_RESET;
      cfg_q.vtx_pattern    <= dsm_sfd_pkg::VTX_PATTERN_RESET;
    end else if (cfg_we_i) begin
      unique case (dsm_sfd_pkg::cfg_reg_e'(cfg_index_i))
        dsm_sfd_pkg::CFG_HIRES_MODE:    cfg_q.hires_mode     <= cfg_data_i[0];
        dsm_sfd_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count  <= cfg_data_i[3:0];
        dsm_sfd_pkg::CFG_SKIP_CHANNEL:  cfg_q.skip_channel   <= cfg_data_i[3:0];
        dsm_sfd_pkg::CFG_GAP_TIMEOUT:   cfg_q.gap_timeout_us <= cfg_data_i[15:0];
        dsm_sfd_pkg::CFG_VTX_MASK:      cfg_q.vtx_mask       <= cfg_data_i[31:0];
        dsm_sfd_pkg::CFG_VTX_PATTERN:   cfg_q.vtx_pattern    <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  dsm_sfd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .frame_done_i (frame_done),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  dsm_sfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dsm_sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  dsm_sfd_back #(
    .FRAME_BYTES  (FRAME_BYTES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .frame_done_o (frame_done),
    .out_o        (out_o)
  );

  `DSM_ASSERT_NEVER(a_queue_no_overflow, q_push && q_full, "queue push while full")
  `DSM_ASSERT_NEVER(a_queue_no_underflow, q_pop && q_empty, "queue pop while empty")
  `DSM_ASSERT_IMPLY(a_read_pulse_range, out_o.valid && (out_o.payload.result_kind == dsm_sfd_pkg::KIND_READ), out_o.payload.pulse_us <= dsm_sfd_pkg::PULSE_MAX, "read answer above pulse limit")
endmodule

`default_nettype wire
